>>> hw/rtl/dru_pkg.sv
// ----------------------------------------------------------------------------
// dru_pkg: shared definitions for the dead-reckoning update
// Field widths, configuration register indexes, CORDIC constants and the
// arctangent table in 2^-32 turn units.
// ----------------------------------------------------------------------------
package dru_pkg;

  localparam int DIST_W  = 16;
  localparam int ANGLE_W = 16;
  localparam int POS_W   = 32;
  localparam int TRIG_W  = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 1'b1;

  // CORDIC datapath: Q2.30 vector, angle in 2^-32 turn, with headroom
  localparam int CORDIC_W       = 34;
  localparam int ATAN_ENTRIES   = 24;
  localparam int ATAN_IDX_W     = 5;
  localparam int CORDIC_STEPS_D = 16;

  localparam logic signed [CORDIC_W-1:0] INV_GAIN = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 34'sd16384;

  function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2F9;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/dru_cordic.sv
// ----------------------------------------------------------------------------
// dru_cordic: iterative CORDIC rotation
// Folds the angle into a quarter turn each side of zero, runs one
// micro-rotation per cycle through a shared shift/add unit and rounds
// cosine and sine to Q1.15 with saturation.
// ----------------------------------------------------------------------------
module dru_cordic
  import dru_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_D
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ANGLE_W-1:0]       angle,
  output logic                     done,
  output logic signed [TRIG_W-1:0] cos_out,
  output logic signed [TRIG_W-1:0] sin_out
);

  localparam int STEPS  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_ROUND
  } state_t;

  state_t state;

  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [CORDIC_W-1:0] z;
  logic                       neg;
  logic [STEP_W-1:0]          idx;

  logic signed [ANGLE_W:0]    a_ext;
  logic signed [ANGLE_W:0]    a_fold;
  logic                       fold;
  logic signed [CORDIC_W-1:0] sx;
  logic signed [CORDIC_W-1:0] sy;
  logic signed [CORDIC_W-1:0] at;
  logic signed [CORDIC_W-1:0] xf;
  logic signed [CORDIC_W-1:0] yf;
  logic signed [CORDIC_W-1:0] xr;
  logic signed [CORDIC_W-1:0] yr;

  function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] hi;
    logic signed [CORDIC_W-1:0] lo;
    hi = CORDIC_W'(32767);
    lo = -CORDIC_W'(32768);
    if (v > hi) begin
      return 16'sh7FFF;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[TRIG_W-1:0];
  endfunction

  // Fold angles beyond a quarter turn by half a turn and flip the result
  always_comb begin
    a_ext = {angle[ANGLE_W-1], angle};
    fold  = (a_ext > 17'sd16384) || (a_ext < -17'sd16384);
    if (!fold) begin
      a_fold = a_ext;
    end else if (a_ext > 17'sd0) begin
      a_fold = a_ext - 17'sd32768;
    end else begin
      a_fold = a_ext + 17'sd32768;
    end
  end

  always_comb begin
    sx = x >>> idx;
    sy = y >>> idx;
    at = $signed({2'b00, atan_entry(ATAN_IDX_W'(idx))});
    xf = neg ? -x : x;
    yf = neg ? -y : y;
    xr = (xf + ROUND_HALF) >>> 15;
    yr = (yf + ROUND_HALF) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            x     <= INV_GAIN;
            y     <= '0;
            z     <= {a_fold[ANGLE_W], a_fold, 16'b0};
            neg   <= fold;
            idx   <= '0;
            state <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (!z[CORDIC_W-1]) begin
            x <= x - sy;
            y <= y + sx;
            z <= z - at;
          end else begin
            x <= x + sy;
            y <= y - sx;
            z <= z + at;
          end
          if (idx == LAST_STEP) begin
            state <= ST_ROUND;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_ROUND: begin
          cos_out <= sat_trig(xr);
          sin_out <= sat_trig(yr);
          done    <= 1'b1;
          state   <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/dru_posacc.sv
// ----------------------------------------------------------------------------
// dru_posacc: position accumulator
// Holds the x and y position. One shared 16x16 multiplier forms
// distance*cos and then distance*sin; each product is rounded to Q24.8
// and added to its coordinate with saturation.
// ----------------------------------------------------------------------------
module dru_posacc
  import dru_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_addr,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     start,
  input  logic signed [DIST_W-1:0] travel_dist,
  input  logic signed [TRIG_W-1:0] cos_in,
  input  logic signed [TRIG_W-1:0] sin_in,
  output logic                     done,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y
);

  localparam int PROD_W = DIST_W + TRIG_W;
  localparam int SUM_W  = POS_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_ADD_X,
    ST_MUL_Y,
    ST_ADD_Y
  } state_t;

  state_t state;

  logic signed [TRIG_W-1:0]  cos_r;
  logic signed [TRIG_W-1:0]  sin_r;
  logic signed [TRIG_W-1:0]  trig_sel;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W:0]    prod_rnd;
  logic signed [SUM_W-1:0]   pos_sel;
  logic signed [SUM_W-1:0]   sum;
  logic signed [POS_W-1:0]   sum_sat;

  always_comb begin
    trig_sel = (state == ST_MUL_X) ? cos_r : sin_r;
    prod_rnd = ($signed({prod[PROD_W-1], prod}) + (PROD_W+1)'(16384)) >>> 15;
    pos_sel  = (state == ST_ADD_X) ? SUM_W'(pos_x) : SUM_W'(pos_y);
    sum      = pos_sel + SUM_W'(prod_rnd);
    if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
      sum_sat = 32'sh7FFF_FFFF;
    end else if (sum < SUM_W'(32'sh8000_0000)) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      pos_x <= '0;
      pos_y <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          // load a start position straight into the coordinate
          if (cfg_we && cfg_addr == REG_START_X) begin
            pos_x <= $signed(cfg_data);
          end
          if (cfg_we && cfg_addr == REG_START_Y) begin
            pos_y <= $signed(cfg_data);
          end
          if (start) begin
            cos_r <= cos_in;
            sin_r <= sin_in;
            state <= ST_MUL_X;
          end
        end
        ST_MUL_X: begin
          prod  <= PROD_W'(travel_dist) * PROD_W'(trig_sel);
          state <= ST_ADD_X;
        end
        ST_ADD_X: begin
          pos_x <= sum_sat;
          state <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          prod  <= PROD_W'(travel_dist) * PROD_W'(trig_sel);
          state <= ST_ADD_Y;
        end
        ST_ADD_Y: begin
          pos_y <= sum_sat;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/dead_reckoning_update_top.sv
// ----------------------------------------------------------------------------
// dead_reckoning_update_top: midpoint-heading odometry update
// Takes one odometry step per input word and returns the updated position
// and the heading after the step.
//
// Usage:
//   s_* channel carries steps: travel distance (Q8.8 m), heading before the
//   step and turn (binary angles, 65536 per turn). m_* channel returns the
//   new x and y (Q24.8 m, saturated) and the heading after the full turn.
//   cfg_we/cfg_addr/cfg_data load a start position (index 0 x, 1 y) straight
//   into the position; write only while no step is in flight.
//   A step runs the CORDIC micro-rotations, one per cycle, then a rounding
//   step, then two multiply/add passes through the one multiplier.
//   s_tready is low for the whole step, until its result moves into the
//   output register, so a new step is not accepted while one is in flight.
//   The result sits in an output register, so the next step is accepted while
//   it waits; if m_tready stays low the following result holds internally
//   until the register is free.
//   Reset clears the position to zero and empties the output register.
// ----------------------------------------------------------------------------
module dead_reckoning_update_top
  import dru_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // travel_dist, heading_before, turn_angle
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [79:0]           m_tdata,   // pos_x_out, pos_y_out, heading_after
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRIG,
    ST_ACC,
    ST_OUT
  } state_t;

  state_t state;

  logic                     s_fire;
  logic [ANGLE_W-1:0]       heading_in;
  logic [ANGLE_W-1:0]       turn_in;
  logic [ANGLE_W-1:0]       mid_angle;
  logic signed [DIST_W-1:0] travel_dist;
  logic [ANGLE_W-1:0]       heading_after;
  logic                     trig_done;
  logic signed [TRIG_W-1:0] cos_v;
  logic signed [TRIG_W-1:0] sin_v;
  logic                     acc_start;
  logic                     acc_done;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic                     out_free;

  assign s_tready   = (state == ST_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign heading_in = s_tdata[31:16];
  assign turn_in    = s_tdata[47:32];
  // half turn rounds towards minus infinity
  assign mid_angle  = heading_in + {turn_in[ANGLE_W-1], turn_in[ANGLE_W-1:1]};
  assign acc_start  = (state == ST_TRIG) && trig_done;
  assign out_free   = !m_tvalid || m_tready;

  dru_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (s_fire),
    .angle   (mid_angle),
    .done    (trig_done),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  dru_posacc u_posacc (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .start       (acc_start),
    .travel_dist (travel_dist),
    .cos_in      (cos_v),
    .sin_in      (sin_v),
    .done        (acc_done),
    .pos_x       (pos_x),
    .pos_y       (pos_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // drop the word once taken, unless a new one replaces it this cycle
      if (m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            travel_dist   <= $signed(s_tdata[15:0]);
            heading_after <= heading_in + turn_in;
            state         <= ST_TRIG;
          end
        end
        ST_TRIG: begin
          if (trig_done) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (acc_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold the word until the output register is free
          if (out_free) begin
            m_tdata  <= {heading_after, pos_y, pos_x};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sim/dru_track_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dru_track_checker: position tracker and result check for the odometry update
// Follows step words and start-position writes into its own copy of the
// position, predicts each result word (CORDIC at the midpoint heading,
// rounded products, saturated sums) and compares it with the master side.
// ----------------------------------------------------------------------------
module dru_track_checker
  import dru_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [47:0]           s_tdata,   // travel_dist, heading_before, turn_angle
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [79:0]           m_tdata,   // pos_x_out, pos_y_out, heading_after
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  localparam int ROTATIONS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam longint POS_MAX  = 64'sd2147483647;
  localparam longint POS_MIN  = -64'sd2147483648;
  localparam longint TRIG_MAX = 64'sd32767;
  localparam longint TRIG_MIN = -64'sd32768;
  localparam longint START_GAIN = 64'sd652032874;

  // heading_after sits in the top bits, pos_x_out in the lowest
  typedef struct packed {
    logic [15:0] hdg;
    logic [31:0] y;
    logic [31:0] x;
  } pose_t;

  // arctangent of 2^-i in 2^-32 turn
  longint arctan_turn [ATAN_ENTRIES] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  longint track_x = 0;
  longint track_y = 0;
  pose_t  expected_poses [$];
  int     fails = 0;
  int     queued = 0;

  assign mismatches = fails;
  assign pending    = queued;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint round_q15(input longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic void heading_cos_sin(input logic [15:0] ang,
                                          output longint c, output longint s);
    longint a, x, y, z, nx;
    bit     flip;
    a    = longint'($signed(ang));
    flip = 1'b0;
    // fold into the right half-plane, negate the vector afterwards
    if (a > 16384 || a < -16384) begin
      a    = (a > 0) ? a - 32768 : a + 32768;
      flip = 1'b1;
    end
    z = a * 65536;
    x = START_GAIN;
    y = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arctan_turn[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arctan_turn[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp(round_q15(x), TRIG_MIN, TRIG_MAX);
    s = clamp(round_q15(y), TRIG_MIN, TRIG_MAX);
  endfunction

  // advance the tracked position by one step and return the pose to expect
  function automatic pose_t dead_reckon(input logic [47:0] word);
    logic signed [15:0] step_dist, turn, half_turn;
    logic        [15:0] head, mid;
    longint             c, s;
    pose_t              p;
    step_dist = word[15:0];
    head      = word[31:16];
    turn      = word[47:32];
    half_turn = turn >>> 1;
    mid       = head + half_turn;
    p.hdg     = head + turn;
    heading_cos_sin(mid, c, s);
    track_x = clamp(track_x + round_q15(longint'(step_dist) * c), POS_MIN, POS_MAX);
    track_y = clamp(track_y + round_q15(longint'(step_dist) * s), POS_MIN, POS_MAX);
    p.x = track_x[31:0];
    p.y = track_y[31:0];
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t got, want;
    if (rst) begin
      expected_poses.delete();
      track_x = 0;
      track_y = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_poses.size() == 0) begin
          fails++;
          $error("result word with no step outstanding: x %0d y %0d heading %0d",
                 $signed(got.x), $signed(got.y), got.hdg);
        end else begin
          want = expected_poses.pop_front();
          if (got.x !== want.x) begin
            fails++;
            $error("pos_x_out: expected %0d, got %0d", $signed(want.x), $signed(got.x));
          end
          if (got.y !== want.y) begin
            fails++;
            $error("pos_y_out: expected %0d, got %0d", $signed(want.y), $signed(got.y));
          end
          if (got.hdg !== want.hdg) begin
            fails++;
            $error("heading_after: expected %0d, got %0d", want.hdg, got.hdg);
          end
        end
      end
      // a start write loads the position straight away
      if (cfg_we) begin
        if (cfg_addr == REG_START_X)
          track_x = longint'($signed(cfg_data));
        else if (cfg_addr == REG_START_Y)
          track_y = longint'($signed(cfg_data));
      end
      if (s_tvalid && s_tready)
        expected_poses.push_back(dead_reckon(s_tdata));
    end
    queued = expected_poses.size();
  end

endmodule

>>> sim/tb_dead_reckoning_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dead_reckoning_update_top: stimulus for the odometry update
// Loads start positions between phases, sends directed steps at the angle
// folds, distance extremes and saturation limits, then random steps under
// sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_dead_reckoning_update_top;
  import dru_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [47:0]           s_tdata;   // travel_dist, heading_before, turn_angle
  logic                  m_tvalid;
  logic                  m_tready;
  logic [79:0]           m_tdata;   // pos_x_out, pos_y_out, heading_after
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int steps_sent    = 0;
  int starts_loaded = 0;

  dead_reckoning_update_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  dru_track_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls, or a counted hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic load_start(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    starts_loaded++;
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic offer_step(input logic [15:0] step_dist, input logic [15:0] head,
                            input logic [15:0] turn);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {turn, head, step_dist};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    steps_sent++;
  endtask

  // hold the sender until every result has come back
  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_dist();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [31:0] sx, sy;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    cfg_we   = 1'b0;
    cfg_addr = REG_START_X;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    load_start(REG_START_X, 32'h0000_0000);
    load_start(REG_START_Y, 32'h0000_0000);
    @(negedge clk);
    // compass points, fold boundaries and turn extremes
    offer_step(16'd256,  16'd0,     16'd0);
    offer_step(16'd256,  16'd16384, 16'd0);
    offer_step(16'd256,  16'd32768, 16'd0);
    offer_step(16'd256,  16'd49152, 16'd0);
    offer_step(16'h7FFF, 16'd16384, 16'd0);
    offer_step(16'h7FFF, 16'd16385, 16'd0);
    offer_step(16'h8000, 16'd49152, 16'd0);
    offer_step(16'h8000, 16'd49151, 16'd0);
    offer_step(16'h0001, 16'hFFFF,  16'h8000);
    offer_step(16'hFFFF, 16'd0,     16'h7FFF);
    offer_step(16'd0,    16'd12345, 16'd1);
    offer_step(16'd100,  16'd8192,  16'hFFFF);
    offer_step(16'h7FFF, 16'hFFFF,  16'h7FFF);
    pause_until_drained();

    // drive x into its upper limit and y into its lower one
    load_start(REG_START_X, 32'h7FFF_FC18);
    load_start(REG_START_Y, 32'h8000_03E8);
    @(negedge clk);
    offer_step(16'h7FFF, 16'd0,     16'd0);
    offer_step(16'h7FFF, 16'd49152, 16'd0);
    offer_step(16'h7FFF, 16'd0,     16'd0);
    offer_step(16'h8000, 16'd0,     16'd0);
    pause_until_drained();

    load_start(REG_START_X, 32'h8000_0000);
    load_start(REG_START_Y, 32'h7FFF_FFFF);
    @(negedge clk);
    offer_step(16'h7FFF, 16'd32768, 16'd0);
    offer_step(16'h7FFF, 16'd16384, 16'd0);
    offer_step(16'h8000, 16'd16384, 16'd0);

    for (int p = 0; p < 5; p++) begin
      pause_until_drained();
      sx = $urandom;
      sy = $urandom;
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  sx = 32'h7FFF_0000; sy = 32'h8000_FFFF; end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        3: begin send_idle_pct = 25; stall_pct = 25; sx = 32'h8000_0000; sy = 32'h7FFF_FFFF; end
        default: begin send_idle_pct = 0; stall_pct = 0; sx = '0; sy = '0; end
      endcase
      // in the third phase x carries on from where it got to
      if (p != 2)
        load_start(REG_START_X, sx);
      load_start(REG_START_Y, sy);
      @(negedge clk);
      for (int k = 0; k < 80; k++) begin
        if (p == 0 && k == 25)
          hold_req = 1'b1;
        if (p == 4 && k == 40)
          pause_until_drained();
        offer_step(pick_dist(), 16'($urandom), 16'($urandom));
      end
    end

    pause_until_drained();
    repeat (30) @(negedge clk);
    $display("Sent %0d odometry steps across %0d start-position writes,", steps_sent,
             starts_loaded);
    $display("with fold and saturation corners, sender gaps, stalls and a long hold-off.");
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> dead_reckoning_update_top.f
hw/rtl/dru_pkg.sv
hw/rtl/dru_cordic.sv
hw/rtl/dru_posacc.sv
hw/rtl/dead_reckoning_update_top.sv
sim/dru_track_checker.sv
sim/tb_dead_reckoning_update_top.sv
